>>> rtl/harmonic_coefficient_scaler_defines.svh
// Assertion macros used by the bound checker module hcs_checker.
`ifndef HARMONIC_COEFFICIENT_SCALER_DEFINES_SVH
`define HARMONIC_COEFFICIENT_SCALER_DEFINES_SVH

// Property checked on every clock edge outside of reset.
`define HCS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define HCS_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/hcs_pkg.sv
package hcs_pkg;

	// Input operation codes.
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_SCALE = 1'b1;

	// Configuration register indexes.
	localparam logic REG_ORDER = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

	// Canonical quiet NaN.
	localparam logic [31:0] QNAN = 32'h7FC00000;

	// One coefficient with its weight, as queued for the multiplier.
	typedef struct packed {
		logic [31:0] value;
		logic [31:0] weight;
		logic        last;
	} entry_t;

endpackage

>>> rtl/hcs_front.sv
module hcs_front
	import hcs_pkg::*;
#(
	parameter int MAX_ORDER   = 32,
	parameter int TABLE_DEPTH = 1088
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        accept,
	input  logic        operation,
	input  logic [10:0] weight_slot,
	input  logic [31:0] value,
	output logic        push,
	output entry_t      push_entry
);

	localparam int RLW = $clog2(MAX_ORDER + 2);
	localparam int BW  = $clog2((MAX_ORDER + 1) * (MAX_ORDER + 1) + 1);
	localparam int IW  = $clog2(TABLE_DEPTH);

	logic [5:0]     order_q;
	logic [11:0]    count_q;
	logic [RLW-1:0] row_length_q;
	logic [RLW-1:0] row_position_q;
	logic [11:0]    surface_index_q;
	logic           sine_phase_q;
	logic [BW-1:0]  block_base_q;

	logic [31:0]    weight_mem [TABLE_DEPTH];
	logic [31:0]    rd_data_q;

	logic           valid_s1;
	logic [31:0]    value_s1;
	logic           last_s1;
	logic           in_range_s1;

	logic [5:0]     order_src;
	logic [RLW-1:0] restart_length;
	logic [RLW-1:0] cur_restart_length;
	logic [11:0]    eff_count;
	logic [BW:0]    weight_index;
	logic           index_ok;
	logic [RLW:0]   pos_next;
	logic [12:0]    surf_next;
	logic           row_done;
	logic           block_done;
	logic           is_last;
	logic           scale_acc;
	logic           load_acc;

	// Clamp an order code into its usable range and give the row length that a set starts with.
	function automatic logic [RLW-1:0] first_length(input logic [5:0] o);
		logic [6:0] e;
		e = {1'b0, o};
		if (e == 7'd0) begin
			e = 7'd1;
		end else if (32'(e) > MAX_ORDER) begin
			e = 7'(MAX_ORDER);
		end
		return RLW'(e) + RLW'(1);
	endfunction

	assign scale_acc = accept && (operation == OP_SCALE);
	assign load_acc  = accept && (operation == OP_LOAD);

	// Counter position decode for the current coefficient.
	always_comb begin
		order_src          = (cfg_index == REG_ORDER) ? cfg_data[5:0] : order_q;
		restart_length     = first_length(order_src);
		cur_restart_length = first_length(order_q);
		eff_count          = (count_q == 12'd0) ? 12'd1 : count_q;
		weight_index       = (BW + 1)'(block_base_q) + (BW + 1)'(row_position_q);
		index_ok           = 32'(weight_index) < TABLE_DEPTH;
		pos_next           = (RLW + 1)'(row_position_q) + (RLW + 1)'(1);
		surf_next          = {1'b0, surface_index_q} + 13'd1;
		row_done           = pos_next >= (RLW + 1)'(row_length_q);
		block_done         = surf_next >= {1'b0, eff_count};
		is_last            = !sine_phase_q && (row_length_q == RLW'(1)) && block_done && row_done;
	end

	// Registers and the position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q         <= 6'd1;
			count_q         <= 12'd1;
			row_length_q    <= RLW'(2);
			row_position_q  <= '0;
			surface_index_q <= '0;
			sine_phase_q    <= 1'b0;
			block_base_q    <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_ORDER) begin
				order_q <= cfg_data[5:0];
			end else begin
				count_q <= cfg_data;
			end
			row_length_q    <= restart_length;
			row_position_q  <= '0;
			surface_index_q <= '0;
			sine_phase_q    <= 1'b0;
			block_base_q    <= '0;
		end else if (scale_acc) begin
			if (!row_done) begin
				row_position_q <= pos_next[RLW-1:0];
			end else begin
				row_position_q <= '0;
				if (!block_done) begin
					surface_index_q <= surf_next[11:0];
				end else begin
					surface_index_q <= '0;
					block_base_q    <= block_base_q + BW'(row_length_q);
					if (block_base_q == '0) begin
						row_length_q <= row_length_q - RLW'(1);
						sine_phase_q <= 1'b0;
					end else if (!sine_phase_q) begin
						if (row_length_q <= RLW'(1)) begin
							row_length_q <= cur_restart_length;
							block_base_q <= '0;
						end else begin
							sine_phase_q <= 1'b1;
						end
					end else begin
						sine_phase_q <= 1'b0;
						row_length_q <= row_length_q - RLW'(1);
					end
				end
			end
		end
	end

	// Weight table write port.
	always_ff @(posedge clk) begin
		if (load_acc && (32'(weight_slot) < TABLE_DEPTH)) begin
			weight_mem[IW'(weight_slot)] <= value;
		end
	end

	// Weight table read port.
	always_ff @(posedge clk) begin
		if (scale_acc) begin
			rd_data_q <= weight_mem[IW'(weight_index)];
		end
	end

	// Lookup stage: holds the coefficient while the table is read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= scale_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (scale_acc) begin
			value_s1    <= value;
			last_s1     <= is_last;
			in_range_s1 <= index_ok;
		end
	end

	assign push              = valid_s1;
	assign push_entry.value  = value_s1;
	assign push_entry.weight = in_range_s1 ? rd_data_q : 32'd0;
	assign push_entry.last   = last_s1;

endmodule

>>> rtl/hcs_queue.sv
module hcs_queue
	import hcs_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  entry_t         push_entry,
	input  logic           pop,
	output entry_t         head,
	output logic           empty,
	output logic [QCW-1:0] count
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	entry_t          slots [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [QCW-1:0]  count_q;

	// Pointer and occupancy tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= push_entry;
		end
	end

	assign head  = slots[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

endmodule

>>> rtl/hcs_fmul.sv
module hcs_fmul
	import hcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  logic        in_valid,
	input  entry_t      in_entry,
	output logic        res_valid,
	output logic [31:0] res_product,
	output logic        res_last
);

	// Stage 1: mantissa product and exponent sum.
	logic               valid_s1, sign_s1, nan_s1, inf_s1, zero_s1, last_s1;
	logic [47:0]        prod_s1;
	logic signed [10:0] exp_s1;
	// Stage 2: leading zero count.
	logic               valid_s2, sign_s2, nan_s2, inf_s2, zero_s2, last_s2;
	logic [47:0]        prod_s2;
	logic signed [10:0] exp_s2;
	logic [5:0]         lz_s2;
	// Stage 3: alignment.
	logic               valid_s3, sign_s3, nan_s3, inf_s3, zero_s3, last_s3;
	logic [47:0]        sh_s3;
	logic               sticky_s3;
	logic [10:0]        exp_s3;
	// Stage 4: rounded result.
	logic               valid_s4, last_s4;
	logic [31:0]        product_s4;

	logic [7:0]         ea, eb;
	logic [22:0]        fa, fb;
	logic               nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
	logic [5:0]         lz;
	logic signed [11:0] norm_exp;
	logic [6:0]         rshift;
	logic [47:0]        sh;
	logic               sticky;
	logic [10:0]        exp_out;
	logic               guard, round_sticky, inc;
	logic [24:0]        mant;
	logic [10:0]        biased;
	logic [33:0]        packed_sum;
	logic [31:0]        product;

	// Operand unpack and classification.
	always_comb begin
		ea     = in_entry.value[30:23];
		fa     = in_entry.value[22:0];
		eb     = in_entry.weight[30:23];
		fb     = in_entry.weight[22:0];
		nan_a  = (ea == 8'hFF) && (fa != '0);
		nan_b  = (eb == 8'hFF) && (fb != '0);
		inf_a  = (ea == 8'hFF) && (fa == '0);
		inf_b  = (eb == 8'hFF) && (fb == '0);
		zero_a = (ea == 8'h00) && (fa == '0);
		zero_b = (eb == 8'h00) && (fb == '0);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s1 <= 48'({ea != 8'h00, fa}) * 48'({eb != 8'h00, fb});
			exp_s1  <= 11'(signed'({3'b0, (ea == 8'h00) ? 8'd1 : ea}))
				+ 11'(signed'({3'b0, (eb == 8'h00) ? 8'd1 : eb})) - 11'sd126;
			sign_s1 <= in_entry.value[31] ^ in_entry.weight[31];
			nan_s1  <= nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b);
			inf_s1  <= inf_a || inf_b;
			zero_s1 <= zero_a || zero_b;
			last_s1 <= in_entry.last;
		end
	end

	// Leading zero search over the mantissa product.
	always_comb begin
		lz = 6'd47;
		for (int i = 0; i < 48; i++) begin
			if (prod_s1[i]) begin
				lz = 6'(47 - i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s2 <= prod_s1;
			exp_s2  <= exp_s1;
			lz_s2   <= lz;
			sign_s2 <= sign_s1;
			nan_s2  <= nan_s1;
			inf_s2  <= inf_s1;
			zero_s2 <= zero_s1;
			last_s2 <= last_s1;
		end
	end

	// Normalize, or align into the subnormal range with a sticky bit.
	always_comb begin
		norm_exp = 12'(exp_s2) - 12'(signed'({1'b0, lz_s2}));
		sticky   = 1'b0;
		rshift   = 7'd0;
		if (norm_exp >= 12'sd1) begin
			sh      = prod_s2 << lz_s2;
			exp_out = 11'(norm_exp);
		end else if (exp_s2 >= 11'sd1) begin
			sh      = prod_s2 << 6'(exp_s2 - 11'sd1);
			exp_out = 11'd0;
		end else begin
			rshift  = (exp_s2 < -11'sd47) ? 7'd48 : 7'(11'sd1 - exp_s2);
			sh      = prod_s2 >> rshift;
			sticky  = |(prod_s2 & ((48'd1 << rshift) - 48'd1));
			exp_out = 11'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sh_s3     <= sh;
			sticky_s3 <= sticky;
			exp_s3    <= exp_out;
			sign_s3   <= sign_s2;
			nan_s3    <= nan_s2;
			inf_s3    <= inf_s2;
			zero_s3   <= zero_s2;
			last_s3   <= last_s2;
		end
	end

	// Round to nearest even and pack; a rounding carry moves into the exponent.
	always_comb begin
		guard        = sh_s3[23];
		round_sticky = (|sh_s3[22:0]) || sticky_s3;
		inc          = guard && (round_sticky || sh_s3[24]);
		mant         = {1'b0, sh_s3[47:24]} + 25'(inc);
		biased       = (exp_s3 == 11'd0) ? 11'd0 : exp_s3 - 11'd1;
		packed_sum   = {biased, 23'd0} + {9'd0, mant};
		if (nan_s3) begin
			product = QNAN;
		end else if (inf_s3) begin
			product = {sign_s3, 8'hFF, 23'd0};
		end else if (zero_s3) begin
			product = {sign_s3, 31'd0};
		end else if (packed_sum[33:23] >= 11'd255) begin
			product = {sign_s3, 8'hFF, 23'd0};
		end else begin
			product = {sign_s3, packed_sum[30:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			product_s4 <= product;
			last_s4    <= last_s3;
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	assign res_valid   = valid_s4;
	assign res_product = product_s4;
	assign res_last    = last_s4;

endmodule

>>> rtl/harmonic_coefficient_scaler.sv
// Channel  | handshake           | payload
// in       | in_valid, in_stall   | operation, weight_slot, value
// out      | out_valid, out_stall | product, last
// cfg      | cfg_we               | cfg_index, cfg_data
//
// One transaction per cycle in and out while neither side stalls; a coefficient's result
// passes through the table read, the queue and four multiplier stages.
// Weight loads produce no result and are written to the table on acceptance.
// Reset clears the counters and pipeline; the weight table is not cleared.
// An output stall freezes the multiplier; the front keeps accepting until the
// four-entry queue is full.
module harmonic_coefficient_scaler
	import hcs_pkg::*;
#(
	parameter int MAX_ORDER   = 32,
	parameter int TABLE_DEPTH = 1088
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [10:0] weight_slot,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] product,
	output logic        last
);

	logic           accept;
	logic           push;
	entry_t         push_entry;
	entry_t         head;
	logic           empty;
	logic [QCW-1:0] q_count;
	logic           advance;
	logic           pop;

	// Hold off input while the queue could not absorb an item in flight.
	assign in_stall = (32'(q_count) + 32'(push)) >= QUEUE_DEPTH;
	assign accept   = in_valid && !in_stall;
	assign advance  = !(out_valid && out_stall);
	assign pop      = advance && !empty;

	hcs_front #(
		.MAX_ORDER   (MAX_ORDER),
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.accept      (accept),
		.operation   (operation),
		.weight_slot (weight_slot),
		.value       (value),
		.push        (push),
		.push_entry  (push_entry)
	);

	hcs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (empty),
		.count      (q_count)
	);

	hcs_fmul u_fmul (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.in_valid    (pop),
		.in_entry    (head),
		.res_valid   (out_valid),
		.res_product (product),
		.res_last    (last)
	);

endmodule

>>> rtl/hcs_checker.sv
`include "harmonic_coefficient_scaler_defines.svh"

module hcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] product
);

	// A stalled result transaction stays offered.
	`HCS_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid, "result dropped under stall")

	// Every NaN result is the canonical quiet NaN.
	`HCS_ASSERT(a_nan_canon, clk, arst_n, out_valid && (product[30:23] == 8'hFF) && (product[22:0] != 23'd0) |-> (product == 32'h7FC00000), "non-canonical NaN")

	// Leaving reset the block is empty: ready for input and offering nothing.
	`HCS_ASSERT_ALWAYS(a_reset_idle, clk, $rose(arst_n) |-> !in_stall && !out_valid, "not idle after reset")

endmodule

bind harmonic_coefficient_scaler hcs_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.product   (product)
);

>>> dv/harmonic_coefficient_scaler_checker.sv
// Watches the configuration port and both channels, predicts every scaled
// coefficient and compares it with the block's output.
module harmonic_coefficient_scaler_checker
	import hcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        operation,
	input  logic [10:0] weight_slot,
	input  logic [31:0] value,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] product,
	input  logic        last,
	output int          errors,
	output int          pending,
	output int          sets_done
);

	localparam int ORDER_CAP = 32;
	localparam int WEIGHTS   = 1088;

	typedef struct packed {
		logic [31:0] product;
		logic        last;
	} scaled_t;

	scaled_t     scaled_q[$];
	logic [31:0] weights[0:WEIGHTS-1];
	logic [5:0]  order_r;
	logic [11:0] count_r;
	int          row_len, row_pos, surf, base;
	logic        sine;

	assign pending = scaled_q.size();

	// Single-precision multiply, round to nearest even, one canonical NaN.
	function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
		logic        sgn;
		int          ea, eb, er, p, sh;
		logic [23:0] ma, mb;
		logic [47:0] sig;
		logic [24:0] keep;
		logic        guard, sticky;
		sgn = a[31] ^ b[31];
		if ((a[30:23] == 8'hFF && a[22:0] != 0) || (b[30:23] == 8'hFF && b[22:0] != 0))
			return QNAN;
		if (a[30:23] == 8'hFF)
			return (b[30:0] == 0) ? QNAN : {sgn, 8'hFF, 23'h0};
		if (b[30:23] == 8'hFF)
			return (a[30:0] == 0) ? QNAN : {sgn, 8'hFF, 23'h0};
		if (a[30:0] == 0 || b[30:0] == 0)
			return {sgn, 31'h0};
		ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
		eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
		ma = {a[30:23] != 0, a[22:0]};
		mb = {b[30:23] != 0, b[22:0]};
		sig = 48'(ma) * 48'(mb);
		p = 47;
		while (!sig[p])
			p--;
		er = ea + eb - 173 + p;
		sig = sig << (47 - p);
		sticky = 1'b0;
		// Results below the normal range are shifted into subnormal form.
		if (er <= 0) begin
			sh = 1 - er;
			if (sh >= 48) begin
				sticky = 1'b1;
				sig = '0;
			end else begin
				sticky = |(sig & ((48'h1 << sh) - 48'h1));
				sig = sig >> sh;
			end
			er = 0;
		end
		keep = {1'b0, sig[47:24]};
		guard = sig[23];
		sticky = sticky | (|sig[22:0]);
		if (guard && (sticky || keep[0]))
			keep = keep + 25'h1;
		if (keep[24]) begin
			keep = keep >> 1;
			er = er + 1;
		end
		if (er == 0 && keep[23])
			er = 1;
		if (er >= 255)
			return {sgn, 8'hFF, 23'h0};
		return {sgn, 8'(er), keep[22:0]};
	endfunction

	// Counters go back to the start of a set under the current registers.
	task automatic restart_set();
		int eff;
		eff = (order_r == 0) ? 1 : (order_r > ORDER_CAP) ? ORDER_CAP : int'(order_r);
		row_len = eff + 1;
		row_pos = 0;
		surf = 0;
		sine = 1'b0;
		base = 0;
	endtask

	// Works out one coefficient's product and advances the position counters.
	task automatic scale_coefficient(input logic [31:0] coef);
		int          idx, cnt;
		logic [31:0] w;
		logic        is_last;
		scaled_t     s;
		cnt = (count_r == 0) ? 1 : int'(count_r);
		idx = base + row_pos;
		w = (idx < WEIGHTS) ? weights[idx] : 32'h0;
		is_last = !sine && row_len == 1 && surf + 1 >= cnt && row_pos + 1 >= row_len;
		s.product = fp_mul(coef, w);
		s.last = is_last;
		scaled_q.push_back(s);
		row_pos++;
		if (row_pos >= row_len) begin
			row_pos = 0;
			surf++;
			if (surf >= cnt) begin
				surf = 0;
				if (base == 0) begin
					base = base + row_len;
					row_len--;
					sine = 1'b0;
				end else if (!sine) begin
					base = base + row_len;
					if (row_len <= 1)
						restart_set();
					else
						sine = 1'b1;
				end else begin
					base = base + row_len;
					sine = 1'b0;
					row_len--;
				end
			end
		end
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
		errors++;
	endtask

	// Outputs are compared first, then the accepted input and any register write.
	// During reset the predictor returns to the block's reset state.
	always @(posedge clk) begin
		scaled_t s;
		if (!arst_n) begin
			errors = 0;
			sets_done = 0;
			order_r = 6'd1;
			count_r = 12'd1;
			scaled_q.delete();
			restart_set();
		end else begin
			if (out_valid && !out_stall) begin
				if (scaled_q.size() == 0) begin
					report("unexpected transaction", product, 32'h0);
				end else begin
					s = scaled_q.pop_front();
					if (product !== s.product)
						report("product", product, s.product);
					if (last !== s.last)
						report("last", 32'(last), 32'(s.last));
					if (s.last)
						sets_done++;
				end
			end
			if (in_valid && !in_stall) begin
				if (operation == OP_LOAD) begin
					if (weight_slot < WEIGHTS)
						weights[weight_slot] = value;
				end else begin
					scale_coefficient(value);
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_ORDER)
					order_r = cfg_data[5:0];
				else
					count_r = cfg_data;
				restart_set();
			end
		end
	end

endmodule

>>> dv/tb.sv
// Drives the scaler with weight loads and coefficient streams under several
// register settings and idle patterns; the checker does the comparison.
module tb;
	import hcs_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [11:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        operation;
	logic [10:0] weight_slot;
	logic [31:0] value;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] product;
	logic        last;
	int          errors, pending, sets_done;
	int          cycles = 0;
	int          sent, in_idle_pct, out_stall_pct;

	harmonic_coefficient_scaler u_dut (.*);

	harmonic_coefficient_scaler_checker u_chk (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Run limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > 300000) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// The receiver stalls at random according to the current idle pattern.
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < out_stall_pct);

	// Floating-point patterns with the special classes well represented.
	function automatic logic [31:0] float_pattern();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(11))
			0: r = {r[31], 31'h0};
			1: r = {r[31], 8'hFF, 23'h0};
			2: r = {r[31], 8'hFF, r[22:0] | 23'h1};
			3: r = {r[31], 8'h00, r[22:0]};
			4: r = {r[31], 8'(126 + $urandom_range(2)), r[22:0]};
			5: r = {r[31], 8'(1 + $urandom_range(20)), r[22:0]};
			6: r = {r[31], 8'(234 + $urandom_range(20)), r[22:0]};
			default: ;
		endcase
		return r;
	endfunction

	// Sends one transaction, with idle cycles ahead of it as the pattern asks.
	task automatic send(input logic op, input logic [10:0] slot, input logic [31:0] v);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		operation = op;
		weight_slot = slot;
		value = v;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		in_valid = 1'b0;
		sent++;
	endtask

	// Waits for all results, then lets the pipeline drain.
	task automatic drain();
		while (pending != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [11:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	logic [31:0] corner_values[12] = '{32'h00000000, 32'h80000000, 32'h7F800000,
		32'hFF800000, 32'h7FC00000, 32'h7F800001, 32'h00000001, 32'h007FFFFF,
		32'h7F7FFFFF, 32'h00800000, 32'hFFFFFFFF, 32'h3F800000};
	int          orders[8] = '{0, 1, 32, 63, 3, 2, 5, 32};
	int          counts[8] = '{1, 0, 1, 2, 4095, 3, 2, 4095};

	initial begin
		sent = 0;
		in_idle_pct = 0;
		out_stall_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ORDER;
		cfg_data = '0;
		in_valid = 1'b0;
		operation = OP_LOAD;
		weight_slot = '0;
		value = '0;
		out_stall = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Fill the whole weight table so that every later read is defined.
		for (int i = 0; i < 1088; i++)
			send(OP_LOAD, 11'(i), (i < 12) ? corner_values[i] : float_pattern());

		// Corner coefficients against corner weights, plus ignored slots.
		send(OP_LOAD, 11'd2047, 32'hFFFFFFFF);
		send(OP_LOAD, 11'd1088, 32'h00000000);
		for (int i = 0; i < 12; i++) begin
			send(OP_LOAD, 11'(i % 3), corner_values[(i * 5) % 12]);
			send(OP_SCALE, 11'h7FF, corner_values[i]);
		end
		drain();

		// Register settings, each paired with one of four idle patterns.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
				1: begin in_idle_pct = 45; out_stall_pct = 0;  end
				2: begin in_idle_pct = 0;  out_stall_pct = 45; end
				default: begin in_idle_pct = 18; out_stall_pct = 18; end
			endcase
			write_reg(REG_ORDER, 12'(orders[ph]));
			write_reg(REG_COUNT, 12'(counts[ph]));
			for (int n = 0; n < 100; n++) begin
				if (ph == 2 && n == 50)
					while (pending != 0)
						@(negedge clk);
				if ($urandom_range(99) < 85)
					send(OP_SCALE, 11'($urandom), float_pattern());
				else
					send(OP_LOAD, 11'($urandom), float_pattern());
			end
			drain();
		end

		$display("sent %0d transactions over 8 register settings and 4 idle patterns,",
			sent);
		$display("and %0d complete coefficient sets came back", sets_done);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
